>>> hdl/mfpf_pkg.sv
// shared constants and control types for the most frequent prime factor unit
`timescale 1ns / 1ps
package mfpf_pkg;

  localparam int VALUE_WIDTH = 31;
  localparam int COUNT_WIDTH = 5;
  localparam int RUN_WIDTH   = $clog2(VALUE_WIDTH + 1);
  localparam int SQ_WIDTH    = VALUE_WIDTH + 1;
  localparam int DCNT_WIDTH  = $clog2(VALUE_WIDTH);
  localparam int SAT_WIDTH   = (RUN_WIDTH > COUNT_WIDTH) ? RUN_WIDTH : COUNT_WIDTH;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = COUNT_WIDTH'(31);
  localparam logic [VALUE_WIDTH-1:0] FIRST_DIVISOR = VALUE_WIDTH'(2);
  localparam logic [SQ_WIDTH-1:0] FIRST_SQUARE = SQ_WIDTH'(4);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic div_take;
    logic next_div;
    logic finish;
  } mfpf_cmd_t;

  typedef struct packed {
    logic rest_gt1;
    logic sq_le_rest;
    logic div_last;
    logic rem_zero;
    logic out_busy;
  } mfpf_status_t;

endpackage

>>> hdl/mfpf_in_if.sv
// input channel interface carrying the number to factor
`timescale 1ns / 1ps
interface mfpf_in_if;
  import mfpf_pkg::*;

  logic   valid;
  logic   ready;
  value_t number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

>>> hdl/mfpf_out_if.sv
// result channel interface carrying the best factor and its count
`timescale 1ns / 1ps
interface mfpf_out_if;
  import mfpf_pkg::*;

  logic   valid;
  logic   ready;
  value_t best_factor;
  count_t best_count;

  modport source (output valid, output best_factor, output best_count, input ready);
  modport sink (input valid, input best_factor, input best_count, output ready);
endinterface

>>> hdl/mfpf_ctrl.sv
// controller state machine sequencing trial division
`timescale 1ns / 1ps
module mfpf_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  mfpf_pkg::mfpf_status_t status,
  output mfpf_pkg::mfpf_cmd_t    cmd
);
  import mfpf_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_AGAIN = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.rest_gt1 && status.sq_le_rest) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (status.rem_zero) begin
          cmd.div_take = 1'b1;
          state_nxt    = S_AGAIN;
        end else begin
          cmd.next_div = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_AGAIN: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/mfpf_datapath.sv
// datapath: remainder, divisor, running square, serial divider and result register
`timescale 1ns / 1ps
module mfpf_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mfpf_pkg::mfpf_cmd_t    cmd,
  output mfpf_pkg::mfpf_status_t status,
  input  mfpf_pkg::value_t       in_number,
  output logic                   out_valid,
  input  logic                   out_ready,
  output mfpf_pkg::value_t       out_best_factor,
  output mfpf_pkg::count_t       out_best_count
);
  import mfpf_pkg::*;

  value_t                 rest_r, rest_nxt;
  value_t                 div_r, div_nxt;
  logic [SQ_WIDTH-1:0]    sq_r, sq_nxt;
  logic [RUN_WIDTH-1:0]   run_r, run_nxt;
  logic [RUN_WIDTH-1:0]   bestq_r, bestq_nxt;
  value_t                 bestf_r, bestf_nxt;
  value_t                 rem_r, rem_nxt;
  value_t                 quo_r, quo_nxt;
  logic [DCNT_WIDTH-1:0]  dcnt_r, dcnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  value_t                 outf_r, outf_nxt;
  count_t                 outq_r, outq_nxt;

  logic [VALUE_WIDTH:0]   trial;
  logic [RUN_WIDTH-1:0]   final_q;
  value_t                 final_f;
  logic [SAT_WIDTH-1:0]   final_ext;

  // one quotient bit per cycle
  assign trial = {rem_r, quo_r[VALUE_WIDTH-1]} - {1'b0, div_r};

  always_comb begin
    if (rest_r > VALUE_WIDTH'(1) && bestq_r == '0) begin
      final_f = rest_r;
      final_q = RUN_WIDTH'(1);
    end else begin
      final_f = bestf_r;
      final_q = bestq_r;
    end
    final_ext = SAT_WIDTH'(final_q);
  end

  always_comb begin
    rest_nxt      = rest_r;
    div_nxt       = div_r;
    sq_nxt        = sq_r;
    run_nxt       = run_r;
    bestq_nxt     = bestq_r;
    bestf_nxt     = bestf_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r;
    outf_nxt      = outf_r;
    outq_nxt      = outq_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.load) begin
      rest_nxt  = in_number;
      div_nxt   = FIRST_DIVISOR;
      sq_nxt    = FIRST_SQUARE;
      run_nxt   = '0;
      bestq_nxt = '0;
      bestf_nxt = '0;
    end

    if (cmd.div_start) begin
      rem_nxt  = '0;
      quo_nxt  = rest_r;
      dcnt_nxt = '0;
    end

    if (cmd.div_step) begin
      if (!trial[VALUE_WIDTH]) begin
        rem_nxt = trial[VALUE_WIDTH-1:0];
        quo_nxt = {quo_r[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[VALUE_WIDTH-2:0], quo_r[VALUE_WIDTH-1]};
        quo_nxt = {quo_r[VALUE_WIDTH-2:0], 1'b0};
      end
      dcnt_nxt = dcnt_r + DCNT_WIDTH'(1);
    end

    if (cmd.div_take) begin
      rest_nxt = quo_r;
      run_nxt  = run_r + RUN_WIDTH'(1);
    end

    if (cmd.next_div) begin
      if (run_r > bestq_r) begin
        bestq_nxt = run_r;
        bestf_nxt = div_r;
      end
      run_nxt = '0;
      div_nxt = div_r + VALUE_WIDTH'(1);
      // (d+1)^2 = d^2 + 2d + 1
      sq_nxt  = sq_r + {div_r, 1'b0} + SQ_WIDTH'(1);
    end

    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      outf_nxt      = final_f;
      if (final_ext > SAT_WIDTH'(COUNT_MAX)) begin
        outq_nxt = COUNT_MAX;
      end else begin
        outq_nxt = final_ext[COUNT_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rest_r  <= rest_nxt;
    div_r   <= div_nxt;
    sq_r    <= sq_nxt;
    run_r   <= run_nxt;
    bestq_r <= bestq_nxt;
    bestf_r <= bestf_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    dcnt_r  <= dcnt_nxt;
    outf_r  <= outf_nxt;
    outq_r  <= outq_nxt;
  end

  assign status.rest_gt1   = rest_r > VALUE_WIDTH'(1);
  assign status.sq_le_rest = sq_r <= {1'b0, rest_r};
  assign status.div_last   = dcnt_r == DCNT_WIDTH'(VALUE_WIDTH - 1);
  assign status.rem_zero   = rem_r == '0;
  assign status.out_busy   = out_valid_r && !out_ready;

  assign out_valid       = out_valid_r;
  assign out_best_factor = outf_r;
  assign out_best_count  = outq_r;

endmodule

>>> hdl/most_frequent_prime_factor_unit.sv
// top level of the most frequent prime factor unit
//
// channel   dir  fields                             transfer
// in_chan   in   number[30:0]                       valid && ready
// out_chan  out  best_factor[30:0], best_count[4:0] valid && ready
//
// one item at a time; in_chan.ready is high only while the controller is idle
// each candidate divisor costs one trial division in the serial divider, plus one
// more each time it divides; an item runs candidates from two upward while the
// square of the divisor is no greater than the remainder
// reset clears the controller and the result valid; a stalled result holds in
// the output register and the next number may be taken while it waits
`timescale 1ns / 1ps
module most_frequent_prime_factor_unit (
  input logic     clk,
  input logic     rst_n,
  mfpf_in_if.sink   in_chan,
  mfpf_out_if.source out_chan
);
  import mfpf_pkg::*;

  mfpf_cmd_t    cmd;
  mfpf_status_t status;

  mfpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  mfpf_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_number       (in_chan.number),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_best_factor (out_chan.best_factor),
    .out_best_count  (out_chan.best_count)
  );

endmodule

>>> tb/mfpf_checker.sv
// checker that predicts and compares the best prime factor of every number transfer
`timescale 1ns / 1ps
module mfpf_checker (
  input  logic clk,
  input  logic rst_n,
  mfpf_in_if   in_mon,
  mfpf_out_if  out_mon,
  output int   errors,
  output int   outstanding
);
  import mfpf_pkg::*;

  typedef struct packed {
    value_t best_factor;
    count_t best_count;
  } best_t;

  best_t pending_best[$];
  int    mismatch_count = 0;

  function automatic best_t predict_best(input value_t number);
    longint unsigned rest;
    longint unsigned divisor;
    longint unsigned run;
    longint unsigned top_factor;
    longint unsigned top_count;
    best_t           result;
    rest       = number;
    divisor    = FIRST_DIVISOR;
    top_factor = 0;
    top_count  = 0;
    while (rest > 1 && divisor <= rest / divisor) begin
      run = 0;
      while (rest % divisor == 0) begin
        rest = rest / divisor;
        run++;
      end
      if (run > top_count) begin
        top_count  = run;
        top_factor = divisor;
      end
      divisor++;
    end
    // leftover prime only counts when nothing smaller divided
    if (rest > 1 && top_count == 0) begin
      top_factor = rest;
      top_count  = 1;
    end
    if (top_count > COUNT_MAX) begin
      top_count = COUNT_MAX;
    end
    result.best_factor = value_t'(top_factor);
    result.best_count  = count_t'(top_count);
    return result;
  endfunction

  always @(posedge clk) begin
    best_t want;
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        if (pending_best.size() == 0) begin
          $error("result with no pending number: best_factor %0d best_count %0d",
                 out_mon.best_factor, out_mon.best_count);
          mismatch_count++;
        end else begin
          want = pending_best.pop_front();
          if (out_mon.best_factor !== want.best_factor) begin
            $error("best_factor mismatch: expected %0d, actual %0d",
                   want.best_factor, out_mon.best_factor);
            mismatch_count++;
          end
          if (out_mon.best_count !== want.best_count) begin
            $error("best_count mismatch: expected %0d, actual %0d",
                   want.best_count, out_mon.best_count);
            mismatch_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pending_best.push_back(predict_best(in_mon.number));
      end
    end
    errors      <= mismatch_count;
    outstanding <= pending_best.size();
  end
endmodule

>>> tb/tb_most_frequent_prime_factor_unit.sv
// testbench top: number stimulus, result backpressure, watchdog and verdict
`timescale 1ns / 1ps
module tb_most_frequent_prime_factor_unit;
  import mfpf_pkg::*;

  localparam int RANDOM_ITEMS   = 120;
  localparam int IDLE_PERCENT   = 19;
  localparam int DRAIN_CYCLES   = 4 * (VALUE_WIDTH + 2);
  localparam int WATCHDOG_LIMIT = 250000;
  localparam int DIRECTED_COUNT = 21;
  localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_WIDTH) - 1;

  logic clk;
  logic rst_n      = 1'b0;
  logic sink_ready = 1'b0;
  logic steady     = 1'b0;
  int   errors;
  int   outstanding;
  int   stall_cycles = 0;

  value_t directed_numbers [DIRECTED_COUNT] = '{
    31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd6, 31'd12, 31'd18, 31'd36, 31'd97,
    31'd1024, 31'd2018, 31'd7776, 31'd65521, 31'd999983, 31'd1022117,
    31'h40000000, 31'h7FFFFFFE, 31'd1162261467, 31'h55555555, 31'h2AAAAAAA
  };

  mfpf_in_if  in_chan ();
  mfpf_out_if out_chan ();

  assign out_chan.ready = sink_ready;

  most_frequent_prime_factor_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  mfpf_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit idle_roll();
    return !steady && ($urandom_range(99) < IDLE_PERCENT);
  endfunction

  function automatic value_t random_number();
    int unsigned     pick;
    int unsigned     bits;
    int unsigned     factor;
    longint unsigned product;
    pick = $urandom_range(99);
    if (pick < 40) begin
      bits = $urandom_range(12, 1);
      return value_t'($urandom_range((1 << bits) - 1));
    end else if (pick < 75) begin
      // smooth numbers reach the top bits but factor quickly
      product = 1;
      repeat (40) begin
        factor = $urandom_range(60, 2);
        if (product * factor <= VALUE_MAX) begin
          product = product * factor;
        end
      end
      return value_t'(product);
    end else if (pick < 93) begin
      return value_t'($urandom_range((1 << 18) - 1));
    end else begin
      return value_t'($urandom_range(1));
    end
  endfunction

  task automatic send_number(input value_t number);
    if (idle_roll()) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
      while (idle_roll()) @(posedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.number <= number;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  always @(posedge clk) begin
    sink_ready <= rst_n && (steady || $urandom_range(99) >= IDLE_PERCENT);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_most_frequent_prime_factor_unit failed");
      $finish;
    end
  end

  initial begin
    in_chan.valid  <= 1'b0;
    in_chan.number <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_numbers[i]) begin
      send_number(directed_numbers[i]);
    end

    // hold off until every pending result has drained
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 50 && i < 80);
      send_number(random_number());
    end
    steady = 1'b0;

    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && outstanding == 0) begin
      $display("tb_most_frequent_prime_factor_unit passed");
    end else begin
      $display("tb_most_frequent_prime_factor_unit failed");
    end
    $finish;
  end
endmodule
